// ===== rtl/core/frequency_note_tracker_core_macros.svh =====
// Assertion macros for the frequency note tracker core.
// Depends on nothing; the using module provides clk and arst_n.
`ifndef FREQUENCY_NOTE_TRACKER_CORE_MACROS_SVH
`define FREQUENCY_NOTE_TRACKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FNT_ASSERT_IMP(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define FNT_ASSERT_NXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define FNT_ASSERT_IMP(lbl, a, b, msg)
`define FNT_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ===== rtl/core/fnt_pkg.sv =====
// Shared types, constants and note table for the frequency note tracker.
// No dependencies.
package fnt_pkg;

	localparam int VOICES  = 3;
	localparam int NOTES   = 96;
	localparam int VOICE_W = 2;
	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int NOTE_W  = 7;
	localparam int FREQ_W  = 16;
	localparam int WAVE_W  = 8;
	localparam int ENV_W   = 16;
	localparam int PW_W    = 12;
	localparam int STICK_W = 8;
	localparam int DELTA_W = FREQ_W + 1;
	localparam int DIST_W  = FREQ_W + 1;
	localparam int DIV_CNT_W = $clog2(FREQ_W);

	localparam logic [STICK_W-1:0] STICKY_RESET = 8'd1;
	localparam int TABLE_LEN = 96;

	typedef enum logic [2:0] {
		EV_NEW       = 3'd0,
		EV_CHANGED   = 3'd1,
		EV_SLIDE     = 3'd2,
		EV_STEADY    = 3'd3,
		EV_SILENT    = 3'd4,
		EV_UNCHANGED = 3'd5
	} note_event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SEARCH,
		ST_FINISH
	} top_state_t;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_SCAN,
		SR_DIV
	} srch_state_t;

	typedef struct packed {
		logic              start;
		logic              prev_valid;
		logic [NOTE_W-1:0] prev;
	} srch_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} srch_stat_t;

	localparam logic [FREQ_W-1:0] NOTE_TABLE [TABLE_LEN] = '{
		16'h0117,16'h0127,16'h0139,16'h014b,16'h015f,16'h0174,
		16'h018a,16'h01a1,16'h01ba,16'h01d4,16'h01f0,16'h020e,
		16'h022d,16'h024e,16'h0271,16'h0296,16'h02be,16'h02e8,
		16'h0314,16'h0343,16'h0374,16'h03a9,16'h03e1,16'h041c,
		16'h045a,16'h049c,16'h04e2,16'h052d,16'h057c,16'h05cf,
		16'h0628,16'h0685,16'h06e8,16'h0752,16'h07c1,16'h0837,
		16'h08b4,16'h0939,16'h09c5,16'h0a5a,16'h0af7,16'h0b9e,
		16'h0c4f,16'h0d0a,16'h0dd1,16'h0ea3,16'h0f82,16'h106e,
		16'h1168,16'h1271,16'h138a,16'h14b3,16'h15ee,16'h173c,
		16'h189e,16'h1a15,16'h1ba2,16'h1d46,16'h1f04,16'h20dc,
		16'h22d0,16'h24e2,16'h2714,16'h2967,16'h2bdd,16'h2e79,
		16'h313c,16'h3429,16'h3744,16'h3a8d,16'h3e08,16'h41b8,
		16'h45a1,16'h49c5,16'h4e28,16'h52cd,16'h57ba,16'h5cf1,
		16'h6278,16'h6853,16'h6e87,16'h751a,16'h7c10,16'h8371,
		16'h8b42,16'h9389,16'h9c4f,16'ha59b,16'haf74,16'hb9e2,
		16'hc4f0,16'hd0a6,16'hdd0e,16'hea33,16'hf820,16'hffff
	};

	// Entries past the table read as all ones
	function automatic logic [FREQ_W-1:0] note_entry(input logic [NOTE_W-1:0] idx);
		logic [FREQ_W-1:0] val;
		val = '1;
		for (int i = 0; i < TABLE_LEN; i++) begin
			if (int'(idx) == i) begin
				val = NOTE_TABLE[i];
			end
		end
		return val;
	endfunction

endpackage

// ===== rtl/core/fnt_item_if.sv =====
// Input channel carrying one voice register snapshot per transaction.
// Depends on fnt_pkg.
interface fnt_item_if;
	logic                         valid;
	logic                         ready;
	logic [fnt_pkg::VOICE_W-1:0]  voice;
	logic [fnt_pkg::FREQ_W-1:0]   frequency;
	logic [fnt_pkg::WAVE_W-1:0]   waveform;
	logic [fnt_pkg::ENV_W-1:0]    envelope;
	logic [fnt_pkg::PW_W-1:0]     pulse_width;
	logic                         first_frame;

	modport source (
		output valid, voice, frequency, waveform, envelope, pulse_width, first_frame,
		input  ready
	);
	modport sink (
		input  valid, voice, frequency, waveform, envelope, pulse_width, first_frame,
		output ready
	);
endinterface

// ===== rtl/core/fnt_result_if.sv =====
// Output channel carrying one tracked note result per transaction.
// Depends on fnt_pkg.
interface fnt_result_if;
	logic                                valid;
	logic                                ready;
	logic [fnt_pkg::NOTE_W-1:0]          note_index;
	logic [2:0]                          note_event;
	logic signed [fnt_pkg::DELTA_W-1:0]  freq_delta;
	logic                                wave_changed;
	logic                                envelope_changed;
	logic                                pulse_changed;

	modport source (
		output valid, note_index, note_event, freq_delta, wave_changed,
		       envelope_changed, pulse_changed,
		input  ready
	);
	modport sink (
		input  valid, note_index, note_event, freq_delta, wave_changed,
		       envelope_changed, pulse_changed,
		output ready
	);
endinterface

// ===== rtl/core/fnt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sticky distance scale.
// Depends on fnt_pkg.
module fnt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fnt_pkg::FREQ_W-1:0]   dividend,
	input  logic [fnt_pkg::STICK_W-1:0]  divisor,
	output logic                         done,
	output logic [fnt_pkg::FREQ_W-1:0]   quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [fnt_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [fnt_pkg::STICK_W-1:0]    rem_q;
	logic [fnt_pkg::FREQ_W-1:0]     quo_q;
	logic [fnt_pkg::STICK_W-1:0]    div_q;
	logic [fnt_pkg::STICK_W:0]      trial;
	logic                           ge;
	logic [fnt_pkg::STICK_W:0]      diff;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[fnt_pkg::FREQ_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fnt_pkg::DIV_CNT_W'(fnt_pkg::FREQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[fnt_pkg::STICK_W-1:0] : trial[fnt_pkg::STICK_W-1:0];
			quo_q <= {quo_q[fnt_pkg::FREQ_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/fnt_search.sv =====
// Serial nearest-note search over the table, one entry per cycle while the divider is idle.
// Depends on fnt_pkg and fnt_div.
module fnt_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fnt_pkg::srch_ctrl_t          ctrl,
	input  logic [fnt_pkg::FREQ_W-1:0]   freq,
	input  logic [fnt_pkg::STICK_W-1:0]  sticky,
	output fnt_pkg::srch_stat_t          stat,
	output logic [fnt_pkg::NOTE_W-1:0]   note
);

	fnt_pkg::srch_state_t          state_q, state_d;
	logic [fnt_pkg::NOTE_W-1:0]    idx_q;
	logic [fnt_pkg::DIST_W-1:0]    best_q;
	logic [fnt_pkg::NOTE_W-1:0]    note_q;
	logic [fnt_pkg::FREQ_W-1:0]    entry;
	logic [fnt_pkg::FREQ_W-1:0]    entry_dist;
	logic                          hit;
	logic                          need_div;
	logic                          last;
	logic                          div_start;
	logic                          div_done;
	logic [fnt_pkg::FREQ_W-1:0]    div_quo;

	// Distance to the current entry and the compare against the best so far
	always_comb begin
		entry      = fnt_pkg::note_entry(idx_q);
		entry_dist = (freq > entry) ? (freq - entry) : (entry - freq);
		hit        = {1'b0, entry_dist} < best_q;
		need_div   = hit && ctrl.prev_valid && (idx_q == ctrl.prev) && (sticky > 8'd1);
		last       = idx_q == fnt_pkg::NOTE_W'(fnt_pkg::NOTES - 1);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fnt_pkg::SR_IDLE: begin
				if (ctrl.start) state_d = fnt_pkg::SR_SCAN;
			end
			fnt_pkg::SR_SCAN: begin
				if (need_div) state_d = fnt_pkg::SR_DIV;
				else if (last) state_d = fnt_pkg::SR_IDLE;
			end
			fnt_pkg::SR_DIV: begin
				if (div_done) state_d = last ? fnt_pkg::SR_IDLE : fnt_pkg::SR_SCAN;
			end
			default: state_d = fnt_pkg::SR_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		div_start = (state_q == fnt_pkg::SR_SCAN) && need_div;
		stat.busy = state_q != fnt_pkg::SR_IDLE;
		stat.done = ((state_q == fnt_pkg::SR_SCAN) && !need_div && last) ||
		            ((state_q == fnt_pkg::SR_DIV) && div_done && last);
	end

	// Sequencer and index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnt_pkg::SR_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				fnt_pkg::SR_IDLE: begin
					if (ctrl.start) idx_q <= '0;
				end
				fnt_pkg::SR_SCAN: begin
					if (!need_div) idx_q <= idx_q + 1'b1;
				end
				fnt_pkg::SR_DIV: begin
					if (div_done) idx_q <= idx_q + 1'b1;
				end
				default: idx_q <= '0;
			endcase
		end
	end

	// Best distance and winning note
	always_ff @(posedge clk) begin
		case (state_q)
			fnt_pkg::SR_IDLE: begin
				if (ctrl.start) best_q <= '1;
			end
			fnt_pkg::SR_SCAN: begin
				if (hit) begin
					best_q <= {1'b0, entry_dist};
					note_q <= idx_q;
				end
			end
			fnt_pkg::SR_DIV: begin
				if (div_done) best_q <= {1'b0, div_quo};
			end
			default: best_q <= '1;
		endcase
	end

	// Divider that scales the favored note's distance
	fnt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (entry_dist),
		.divisor  (sticky),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign note = note_q;

endmodule

// ===== rtl/core/frequency_note_tracker_core.sv =====
// Top level of the frequency note tracker: voice state, control and result register.
// Depends on fnt_pkg, fnt_item_if, fnt_result_if, fnt_search and the macros header.
`include "frequency_note_tracker_core_macros.svh"

// Each transaction on item is one voice's register snapshot for a frame; for each voice
// numbered below three the block returns one transaction on result with the tracked note,
// the event class, the slide delta and the register change flags. A snapshot that needs no
// lookup (silent voice, or unchanged frequency with no first frame and no new note) skips
// the search. A lookup scans the 96-entry note table through one shared compare unit, one
// entry per cycle while the divider is idle; when the previous note becomes the best match
// its distance is scaled by the sticky factor in the bit-serial divider, which holds the
// scan. A snapshot for voice three is taken and dropped without a result. item.ready is
// high only while no snapshot is in work; a finished result waits in the output register
// without holding back the next snapshot. The user writes sticky_factor through cfg_we and
// cfg_wdata only while idle; the block does not enforce this. Zero acts as one.
module frequency_note_tracker_core (
	input  logic                         clk,
	input  logic                         arst_n,
	fnt_item_if.sink                     item,
	fnt_result_if.source                 result,
	input  logic                         cfg_we,
	input  logic [fnt_pkg::STICK_W-1:0]  cfg_wdata
);

	fnt_pkg::top_state_t             state_q, state_d;
	logic [fnt_pkg::STICK_W-1:0]     sticky_q;

	// latched snapshot
	logic [fnt_pkg::VOICE_W-1:0]     voice_q;
	logic [fnt_pkg::FREQ_W-1:0]      freq_q;
	logic [fnt_pkg::WAVE_W-1:0]      wave_q;
	logic [fnt_pkg::ENV_W-1:0]       env_q;
	logic [fnt_pkg::PW_W-1:0]        pw_q;
	logic                            first_q;

	// per-voice history
	logic [fnt_pkg::NOTE_W-1:0]      last_note_q [fnt_pkg::VOICES];
	logic [fnt_pkg::FREQ_W-1:0]      last_freq_q [fnt_pkg::VOICES];
	logic [fnt_pkg::WAVE_W-1:0]      last_wave_q [fnt_pkg::VOICES];
	logic [fnt_pkg::ENV_W-1:0]       last_env_q  [fnt_pkg::VOICES];
	logic [fnt_pkg::PW_W-1:0]        last_pw_q   [fnt_pkg::VOICES];

	// result register
	logic                            out_valid_q;
	logic [fnt_pkg::NOTE_W-1:0]      out_note_q;
	fnt_pkg::note_event_t            out_event_q;
	logic signed [fnt_pkg::DELTA_W-1:0] out_delta_q;
	logic                            out_wchg_q;
	logic                            out_echg_q;
	logic                            out_pchg_q;

	logic [fnt_pkg::VIDX_W-1:0]      vidx;
	logic [fnt_pkg::NOTE_W-1:0]      ln;
	logic [fnt_pkg::FREQ_W-1:0]      lf;
	logic [fnt_pkg::WAVE_W-1:0]      lw;
	logic                            sounding;
	logic                            unknown;
	logic                            freq_diff;
	logic                            lookup;
	logic                            in_range;
	logic                            accept;
	logic                            load;
	logic                            out_free;

	fnt_pkg::srch_ctrl_t             srch_ctrl;
	fnt_pkg::srch_stat_t             srch_stat;
	logic [fnt_pkg::NOTE_W-1:0]      srch_note;

	logic [fnt_pkg::NOTE_W-1:0]      new_note;
	fnt_pkg::note_event_t            new_event;
	logic signed [fnt_pkg::DELTA_W-1:0] new_delta;
	logic [fnt_pkg::DELTA_W-1:0]     raw_delta;

	// Look up the voice history and classify the snapshot
	always_comb begin
		vidx      = voice_q[fnt_pkg::VIDX_W-1:0];
		ln        = last_note_q[vidx];
		lf        = last_freq_q[vidx];
		lw        = last_wave_q[vidx];
		sounding  = wave_q[7:4] != 4'd0;
		unknown   = sounding && wave_q[0] && (!lw[0] || (lw[7:4] == 4'd0));
		freq_diff = freq_q != lf;
		lookup    = first_q || unknown || freq_diff;
		in_range  = {1'b0, item.voice} < (fnt_pkg::VOICE_W + 1)'(fnt_pkg::VOICES);
		out_free  = !out_valid_q || result.ready;
		raw_delta = {1'b0, freq_q} - {1'b0, lf};
	end

	// Pick the note and event for the result
	always_comb begin
		new_note  = (lookup && sounding) ? srch_note : ln;
		new_delta = '0;
		if (!lookup) begin
			new_event = fnt_pkg::EV_UNCHANGED;
		end else if (!sounding) begin
			new_event = fnt_pkg::EV_SILENT;
		end else if (unknown) begin
			new_event = fnt_pkg::EV_NEW;
		end else if (srch_note != ln) begin
			new_event = fnt_pkg::EV_CHANGED;
		end else if (freq_diff) begin
			new_event = fnt_pkg::EV_SLIDE;
			new_delta = $signed(raw_delta);
		end else begin
			new_event = fnt_pkg::EV_STEADY;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fnt_pkg::ST_IDLE: begin
				if (item.valid && in_range) state_d = fnt_pkg::ST_DECIDE;
			end
			fnt_pkg::ST_DECIDE: begin
				state_d = (lookup && sounding) ? fnt_pkg::ST_SEARCH : fnt_pkg::ST_FINISH;
			end
			fnt_pkg::ST_SEARCH: begin
				if (srch_stat.done) state_d = fnt_pkg::ST_FINISH;
			end
			fnt_pkg::ST_FINISH: begin
				if (out_free) state_d = fnt_pkg::ST_IDLE;
			end
			default: state_d = fnt_pkg::ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		item.ready           = state_q == fnt_pkg::ST_IDLE;
		accept               = item.valid && (state_q == fnt_pkg::ST_IDLE);
		load                 = (state_q == fnt_pkg::ST_FINISH) && out_free;
		srch_ctrl.start      = (state_q == fnt_pkg::ST_DECIDE) && lookup && sounding;
		srch_ctrl.prev_valid = !unknown;
		srch_ctrl.prev       = ln;
	end

	// State and sticky factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fnt_pkg::ST_IDLE;
			sticky_q <= fnt_pkg::STICKY_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) sticky_q <= cfg_wdata;
		end
	end

	// Capture the snapshot on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			voice_q <= item.voice;
			freq_q  <= item.frequency;
			wave_q  <= item.waveform;
			env_q   <= item.envelope;
			pw_q    <= item.pulse_width;
			first_q <= item.first_frame;
		end
	end

	// Update the voice history when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < fnt_pkg::VOICES; v++) begin
				last_note_q[v] <= '0;
				last_freq_q[v] <= '0;
				last_wave_q[v] <= '0;
				last_env_q[v]  <= '0;
				last_pw_q[v]   <= '0;
			end
		end else if (load) begin
			last_note_q[vidx] <= new_note;
			last_freq_q[vidx] <= freq_q;
			last_wave_q[vidx] <= wave_q;
			last_env_q[vidx]  <= env_q;
			last_pw_q[vidx]   <= pw_q;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_note_q  <= new_note;
			out_event_q <= new_event;
			out_delta_q <= new_delta;
			out_wchg_q  <= first_q || (wave_q != lw);
			out_echg_q  <= first_q || (env_q != last_env_q[vidx]);
			out_pchg_q  <= first_q || (pw_q != last_pw_q[vidx]);
		end
	end

	// Nearest-note search unit
	fnt_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (srch_ctrl),
		.freq   (freq_q),
		.sticky (sticky_q),
		.stat   (srch_stat),
		.note   (srch_note)
	);

	assign result.valid            = out_valid_q;
	assign result.note_index       = out_note_q;
	assign result.note_event       = out_event_q;
	assign result.freq_delta       = out_delta_q;
	assign result.wave_changed     = out_wchg_q;
	assign result.envelope_changed = out_echg_q;
	assign result.pulse_changed    = out_pchg_q;

	// Checks
	`FNT_ASSERT_IMP(a_busy_in_search, srch_stat.busy, state_q == fnt_pkg::ST_SEARCH, "search busy outside search state")
	`FNT_ASSERT_IMP(a_done_in_search, srch_stat.done, state_q == fnt_pkg::ST_SEARCH, "search done outside search state")
	`FNT_ASSERT_NXT(a_accept_blocks, item.valid && item.ready && in_range, !item.ready, "ready stayed high after accepting a snapshot")
	`FNT_ASSERT_IMP(a_load_free, load, !out_valid_q || result.ready, "result loaded over a pending transaction")

endmodule
